FILE: hw/rtl/olr_pkg.sv
// ----------------------------------------------------------------------------
// olr_pkg
// Shared types and codes for the ordered list remove-by-value unit.
// ----------------------------------------------------------------------------
package olr_pkg;

  localparam int CMD_W    = 2;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 3;

  // Command codes carried on the request channel
  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_DUMP   = 2'd2
  } cmd_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_APPENDED = 3'd0,
    STAT_DROPPED  = 3'd1,
    STAT_REMOVED  = 3'd2,
    STAT_NOTFOUND = 3'd3,
    STAT_ENTRY    = 3'd4,
    STAT_EMPTY    = 3'd5
  } status_t;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_RESP,
    S_DUMP
  } state_t;

  // Operation broadcast to every cell of the row
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_MATCH,
    CELL_SHIFT,
    CELL_ROTATE
  } cell_op_t;

  typedef struct packed {
    cell_op_t                 op;
    logic signed [VAL_W-1:0]  value;
  } cell_ctrl_t;

  // Position of one cell relative to the current occupancy
  typedef struct packed {
    logic live;       // cell holds a list entry
    logic tail;       // first free cell
    logic last_live;  // cell holds the final entry
    logic next_live;  // right-hand neighbour holds an entry
  } cell_pos_t;

endpackage

FILE: hw/rtl/olr_if.sv
// ----------------------------------------------------------------------------
// olr_req_if / olr_rsp_if
// Valid/ready channels for requests and results of the list unit.
// ----------------------------------------------------------------------------
interface olr_req_if import olr_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        cmd;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface olr_rsp_if import olr_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [STATUS_W-1:0]     status;
  logic signed [VAL_W-1:0] entry_value;
  logic                    last;

  modport source (output valid, output status, output entry_value, output last,
                  input ready);
  modport sink   (input valid, input status, input entry_value, input last,
                  output ready);
endinterface

FILE: hw/rtl/olr_cell.sv
// ----------------------------------------------------------------------------
// olr_cell
// One storage cell of the list row: loads, compares, shifts and rotates.
// ----------------------------------------------------------------------------
module olr_cell import olr_pkg::*; (
  input  logic                    clk,
  input  cell_ctrl_t              ctrl,
  input  cell_pos_t               pos,
  input  logic signed [VAL_W-1:0] next_data,
  input  logic signed [VAL_W-1:0] head_data,
  input  logic                    kill_in,
  output logic signed [VAL_W-1:0] data,
  output logic                    kill_out
);

  logic match;

  // Pass on whether a match has been seen at or before this cell
  assign kill_out = kill_in | match;

  // Update the held entry and match flag
  always_ff @(posedge clk) begin
    case (ctrl.op)
      CELL_LOAD: begin
        if (pos.tail) begin
          data <= ctrl.value;
        end
      end
      CELL_MATCH: begin
        match <= pos.live && (data == ctrl.value);
      end
      CELL_SHIFT: begin
        if (kill_out && pos.next_live) begin
          data <= next_data;
        end
      end
      CELL_ROTATE: begin
        if (pos.next_live) begin
          data <= next_data;
        end else if (pos.last_live) begin
          data <= head_data;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: hw/rtl/ordered_list_remove_by_value_unit.sv
// ----------------------------------------------------------------------------
// ordered_list_remove_by_value_unit
// Ordered list of signed values held in a row of cells, head at cell 0.
// ----------------------------------------------------------------------------
// Append, and dump of an empty list: accept, then load the result in the
// response state. Remove: compare in every cell, then shift the cells from
// the first match on, then load the result. Dump: one entry per cycle out of
// the head cell while the row rotates, while the output does not stall.
// A request may be accepted while the last result still waits in the output
// register. Synchronous reset empties the list; cell contents are kept.
module ordered_list_remove_by_value_unit import olr_pkg::*; #(
  parameter int DEPTH = 32
) (
  input  logic      clk,
  input  logic      rst,
  olr_req_if.sink   req,
  olr_rsp_if.source rsp
);

  localparam int OW = $clog2(DEPTH + 1);
  localparam logic [OW-1:0] DEPTH_C = OW'(DEPTH);

  state_t                  state, state_next;
  logic [OW-1:0]           occ, occ_next;
  logic [OW-1:0]           cnt;
  logic [OW-1:0]           cnt_inc;
  status_t                 pend_status;
  logic                    acc;
  logic                    slot_free;
  logic                    found;
  logic                    dump_last;
  cell_ctrl_t              ctrl;
  cell_pos_t               pos  [DEPTH];
  logic signed [VAL_W-1:0] data [DEPTH];
  logic                    kill [DEPTH+1];

  logic                    out_valid;
  status_t                 out_status;
  logic signed [VAL_W-1:0] out_value;
  logic                    out_last;
  logic                    out_load;
  status_t                 load_status;
  logic signed [VAL_W-1:0] load_value;
  logic                    load_last;

  assign req.ready = (state == S_IDLE);
  assign acc       = req.valid && req.ready;
  assign slot_free = !out_valid || rsp.ready;
  assign cnt_inc   = cnt + OW'(1);
  assign dump_last = (cnt_inc == occ);
  assign found     = kill[DEPTH];
  assign kill[0]   = 1'b0;

  // Row of cells with per-cell position flags
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [OW:0] IDX = (OW+1)'(i);
    logic signed [VAL_W-1:0] nxt;

    assign pos[i].live      = ({1'b0, occ} > IDX);
    assign pos[i].tail      = ({1'b0, occ} == IDX);
    assign pos[i].last_live = ({1'b0, occ} == IDX + (OW+1)'(1));
    assign pos[i].next_live = ({1'b0, occ} > IDX + (OW+1)'(1));

    if (i == DEPTH - 1) begin : g_end
      assign nxt = data[0];
    end else begin : g_mid
      assign nxt = data[i+1];
    end

    olr_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .pos       (pos[i]),
      .next_data (nxt),
      .head_data (data[0]),
      .kill_in   (kill[i]),
      .data      (data[i]),
      .kill_out  (kill[i+1])
    );
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (acc) begin
          case (cmd_t'(req.cmd))
            CMD_APPEND: state_next = S_RESP;
            CMD_REMOVE: state_next = S_SEARCH;
            CMD_DUMP:   state_next = (occ == '0) ? S_RESP : S_DUMP;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_SEARCH: state_next = S_RESP;
      S_RESP: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      S_DUMP: begin
        if (slot_free && dump_last) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs of the sequencer: cell operation, occupancy, result load
  always_comb begin
    ctrl.op     = CELL_HOLD;
    ctrl.value  = req.value;
    occ_next    = occ;
    out_load    = 1'b0;
    load_status = STAT_ENTRY;
    load_value  = '0;
    load_last   = 1'b1;
    case (state)
      S_IDLE: begin
        if (acc) begin
          case (cmd_t'(req.cmd))
            CMD_APPEND: begin
              ctrl.op = CELL_LOAD;
              if (occ != DEPTH_C) begin
                occ_next = occ + OW'(1);
              end
            end
            CMD_REMOVE: ctrl.op = CELL_MATCH;
            default: begin
            end
          endcase
        end
      end
      S_SEARCH: begin
        ctrl.op = CELL_SHIFT;
        if (found) begin
          occ_next = occ - OW'(1);
        end
      end
      S_RESP: begin
        out_load    = slot_free;
        load_status = pend_status;
      end
      S_DUMP: begin
        if (slot_free) begin
          ctrl.op    = CELL_ROTATE;
          out_load   = 1'b1;
          load_value = data[0];
          load_last  = dump_last;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      occ       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      occ   <= occ_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Pending status, dump counter and result payload
  always_ff @(posedge clk) begin
    if (state == S_IDLE && acc) begin
      cnt <= '0;
      case (cmd_t'(req.cmd))
        CMD_APPEND: pend_status <= (occ == DEPTH_C) ? STAT_DROPPED : STAT_APPENDED;
        CMD_DUMP:   pend_status <= STAT_EMPTY;
        default: begin
        end
      endcase
    end
    if (state == S_SEARCH) begin
      pend_status <= found ? STAT_REMOVED : STAT_NOTFOUND;
    end
    if (state == S_DUMP && slot_free) begin
      cnt <= cnt_inc;
    end
    if (out_load) begin
      out_status <= load_status;
      out_value  <= load_value;
      out_last   <= load_last;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.entry_value = out_value;
  assign rsp.last        = out_last;

  // Occupancy stays within the row
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= DEPTH_C)
    else $error("occupancy beyond depth");

  // An append into a list with room grows it by one
  a_append_grow: assert property (@(posedge clk) disable iff (rst)
    (acc && req.cmd == CMD_APPEND && occ != DEPTH_C) |=> occ == $past(occ) + OW'(1))
    else $error("append did not grow list");

  // A successful search shrinks the list by one
  a_remove_shrink: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEARCH && found) |=> occ == $past(occ) - OW'(1))
    else $error("remove did not shrink list");

  // Every result other than a dumped entry closes its transaction
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status != STAT_ENTRY) |-> rsp.last)
    else $error("single result without last");

endmodule
